// ----- rtl/core/assert_macros.svh -----
// shared assertion macros for the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent in a cycle implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent in a cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/rhp_pkg.sv -----
`default_nettype none

package rhp_pkg;

  // longest packet taken in full; later bytes are dropped
  localparam int MAX_PACKET_BYTES = 2048;
  localparam int PosW = $clog2(MAX_PACKET_BYTES + 1);

  localparam int LenW = 12;
  localparam int LenMax = (1 << LenW) - 1;
  localparam int ExtW = 18;

  // result queue
  localparam int QueueDepth = 4;
  localparam int QueuePtrW = $clog2(QueueDepth);
  localparam int QueueCntW = $clog2(QueueDepth + 1);

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_CSRC = 2'd1;
  localparam logic [1:0] KIND_EXT = 2'd2;
  localparam logic [1:0] KIND_SUMMARY = 2'd3;

  // summary status codes
  localparam logic [2:0] STATUS_OK = 3'd0;
  localparam logic [2:0] STATUS_TRUNCATED = 3'd1;
  localparam logic [2:0] STATUS_EXT_OVERRUN = 3'd2;
  localparam logic [2:0] STATUS_BAD_PADDING = 3'd3;
  localparam logic [2:0] STATUS_OVERSIZE = 3'd4;

  // parser phase
  typedef enum logic [5:0] {
    PH_FIXED   = 6'b000001,
    PH_CSRC    = 6'b000010,
    PH_EXTHDR  = 6'b000100,
    PH_EXTBODY = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_DROP    = 6'b100000
  } phase_t;

  // one result item
  typedef struct packed {
    logic [1:0]      kind;
    logic [31:0]     value;
    logic [1:0]      version;
    logic            marker;
    logic [6:0]      payload_type;
    logic [15:0]     seq_num;
    logic [31:0]     timestamp;
    logic [31:0]     ssrc;
    logic [3:0]      csrc_count;
    logic            extension_present;
    logic [LenW-1:0] payload_length;
    logic [2:0]      status;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/rhp_ifs.sv -----
`default_nettype none

// packet byte channel
interface rhp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       end_of_packet;

  modport source(output valid, packet_byte, end_of_packet, input ready);
  modport sink(input valid, packet_byte, end_of_packet, output ready);
endinterface

// parse result channel
interface rhp_result_if import rhp_pkg::*;;
  logic            valid;
  logic            ready;
  logic [1:0]      kind;
  logic [31:0]     value;
  logic [1:0]      version;
  logic            marker;
  logic [6:0]      payload_type;
  logic [15:0]     seq_num;
  logic [31:0]     timestamp;
  logic [31:0]     ssrc;
  logic [3:0]      csrc_count;
  logic            extension_present;
  logic [LenW-1:0] payload_length;
  logic [2:0]      status;

  modport source(output valid, kind, value, version, marker, payload_type, seq_num,
                 timestamp, ssrc, csrc_count, extension_present, payload_length, status,
                 input ready);
  modport sink(input valid, kind, value, version, marker, payload_type, seq_num,
               timestamp, ssrc, csrc_count, extension_present, payload_length, status,
               output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rtp_header_parser_unit.sv -----
// throughput: one packet byte per cycle while the result queue has room; the last byte of a
// packet yields up to two results (data plus summary), drained one per cycle while
// result.ready is high, from a four-entry result queue
// packet bytes are taken while at least two queue entries are free
// reset (synchronous, active high) clears the parser state and empties the queue
`default_nettype none
`include "assert_macros.svh"

module rtp_header_parser_unit import rhp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  rhp_byte_if.sink   packet,
  rhp_result_if.source result
);

  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_PACKET_BYTES);

  // parser state
  logic [PosW-1:0] byte_position, byte_position_next;
  phase_t          phase, phase_next, cur_phase, after_phase;
  logic [31:0]     word_shift, word_shift_next, shifted;
  logic [15:0]     header_flags, header_flags_next;
  logic [15:0]     held_sequence, held_sequence_next;
  logic [31:0]     held_timestamp, held_timestamp_next;
  logic [31:0]     held_source, held_source_next;
  logic [3:0]      sources_left, sources_left_next;
  logic [ExtW-1:0] extension_bytes_left, extension_bytes_left_next;
  logic [PosW-1:0] payload_count, payload_count_next;

  // per-byte results
  logic            emit;
  logic [1:0]      emit_kind;
  logic [31:0]     emit_value;
  logic [2:0]      sum_status;
  logic [PosW-1:0] len_full;
  logic [LenW-1:0] len_sat;
  result_t         data_res, sum_res;

  // result queue
  result_t               queue [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr, rd_ptr;
  logic [QueueCntW-1:0]  count;
  logic                  take, pop, last;
  logic [1:0]            push_n;

  assign take = packet.valid && packet.ready;
  assign pop = result.valid && result.ready;
  assign last = packet.end_of_packet;
  assign packet.ready = (count <= QueueCntW'(QueueDepth - 2));

  // byte parser
  always_comb begin
    cur_phase = (phase != PH_DROP && byte_position >= MaxPos) ? PH_DROP : phase;
    after_phase = header_flags[12] ? PH_EXTHDR : PH_PAYLOAD;
    shifted = {word_shift[23:0], packet.packet_byte};
    phase_next = cur_phase;
    word_shift_next = word_shift;
    header_flags_next = header_flags;
    held_sequence_next = held_sequence;
    held_timestamp_next = held_timestamp;
    held_source_next = held_source;
    sources_left_next = sources_left;
    extension_bytes_left_next = extension_bytes_left;
    payload_count_next = payload_count;
    emit = 1'b0;
    emit_kind = KIND_PAYLOAD;
    emit_value = '0;
    case (cur_phase)
      PH_FIXED: begin
        if (byte_position < PosW'(2)) begin
          header_flags_next = {header_flags[7:0], packet.packet_byte};
        end else if (byte_position < PosW'(4)) begin
          held_sequence_next = {held_sequence[7:0], packet.packet_byte};
        end else if (byte_position < PosW'(8)) begin
          held_timestamp_next = {held_timestamp[23:0], packet.packet_byte};
        end else begin
          held_source_next = {held_source[23:0], packet.packet_byte};
        end
        if (byte_position == PosW'(11)) begin
          sources_left_next = header_flags[11:8];
          phase_next = (header_flags[11:8] != 4'd0) ? PH_CSRC : after_phase;
        end
      end
      PH_CSRC: begin
        word_shift_next = shifted;
        if (byte_position[1:0] == 2'b11) begin
          emit = 1'b1;
          emit_kind = KIND_CSRC;
          emit_value = shifted;
          sources_left_next = sources_left - 4'd1;
          if (sources_left == 4'd1) begin
            phase_next = after_phase;
          end
        end
      end
      PH_EXTHDR: begin
        word_shift_next = shifted;
        if (byte_position[1:0] == 2'b11) begin
          emit = 1'b1;
          emit_kind = KIND_EXT;
          emit_value = shifted;
          extension_bytes_left_next = {shifted[15:0], 2'b00};
          phase_next = (shifted[15:0] != 16'd0) ? PH_EXTBODY : PH_PAYLOAD;
        end
      end
      PH_EXTBODY: begin
        extension_bytes_left_next = extension_bytes_left - ExtW'(1);
        if (extension_bytes_left == ExtW'(1)) begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        emit = 1'b1;
        emit_kind = KIND_PAYLOAD;
        emit_value = {24'd0, packet.packet_byte};
        payload_count_next = payload_count + PosW'(1);
      end
      default: begin
      end
    endcase
    byte_position_next = (byte_position < MaxPos) ? byte_position + PosW'(1) : byte_position;
  end

  // packet summary status and length
  always_comb begin
    sum_status = STATUS_OK;
    len_full = payload_count_next;
    if (phase_next == PH_DROP) begin
      sum_status = STATUS_OVERSIZE;
    end else if (phase_next == PH_FIXED || phase_next == PH_CSRC || phase_next == PH_EXTHDR) begin
      sum_status = STATUS_TRUNCATED;
    end else if (phase_next == PH_EXTBODY) begin
      sum_status = STATUS_EXT_OVERRUN;
    end else if (header_flags_next[13]) begin
      if (payload_count_next == '0 ||
          32'(packet.packet_byte) > 32'(payload_count_next)) begin
        sum_status = STATUS_BAD_PADDING;
      end else begin
        len_full = payload_count_next - PosW'(packet.packet_byte);
      end
    end
    if (sum_status != STATUS_OK) begin
      len_sat = '0;
    end else if (32'(len_full) > 32'(LenMax)) begin
      len_sat = LenW'(LenMax);
    end else begin
      len_sat = LenW'(len_full);
    end
  end

  // result records
  always_comb begin
    data_res = '0;
    data_res.kind = emit_kind;
    data_res.value = emit_value;
    sum_res = '0;
    sum_res.kind = KIND_SUMMARY;
    sum_res.version = header_flags_next[15:14];
    sum_res.marker = header_flags_next[7];
    sum_res.payload_type = header_flags_next[6:0];
    sum_res.seq_num = held_sequence_next;
    sum_res.timestamp = held_timestamp_next;
    sum_res.ssrc = held_source_next;
    sum_res.csrc_count = header_flags_next[11:8];
    sum_res.extension_present = header_flags_next[12];
    sum_res.payload_length = len_sat;
    sum_res.status = sum_status;
  end

  assign push_n = take ? (2'(emit) + 2'(last)) : 2'd0;

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst || (take && last)) begin
      byte_position <= '0;
      phase <= PH_FIXED;
      word_shift <= '0;
      header_flags <= '0;
      held_sequence <= '0;
      held_timestamp <= '0;
      held_source <= '0;
      sources_left <= '0;
      extension_bytes_left <= '0;
      payload_count <= '0;
    end else if (take) begin
      byte_position <= byte_position_next;
      phase <= phase_next;
      word_shift <= word_shift_next;
      header_flags <= header_flags_next;
      held_sequence <= held_sequence_next;
      held_timestamp <= held_timestamp_next;
      held_source <= held_source_next;
      sources_left <= sources_left_next;
      extension_bytes_left <= extension_bytes_left_next;
      payload_count <= payload_count_next;
    end
  end

  // queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + QueuePtrW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + QueuePtrW'(1);
      end
      count <= count + QueueCntW'(push_n) - QueueCntW'(pop);
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (take) begin
      if (emit) begin
        queue[wr_ptr] <= data_res;
        if (last) begin
          queue[wr_ptr + QueuePtrW'(1)] <= sum_res;
        end
      end else if (last) begin
        queue[wr_ptr] <= sum_res;
      end
    end
  end

  // result transfer
  assign result.valid = (count != '0);
  assign result.kind = queue[rd_ptr].kind;
  assign result.value = queue[rd_ptr].value;
  assign result.version = queue[rd_ptr].version;
  assign result.marker = queue[rd_ptr].marker;
  assign result.payload_type = queue[rd_ptr].payload_type;
  assign result.seq_num = queue[rd_ptr].seq_num;
  assign result.timestamp = queue[rd_ptr].timestamp;
  assign result.ssrc = queue[rd_ptr].ssrc;
  assign result.csrc_count = queue[rd_ptr].csrc_count;
  assign result.extension_present = queue[rd_ptr].extension_present;
  assign result.payload_length = queue[rd_ptr].payload_length;
  assign result.status = queue[rd_ptr].status;

  `ASSERT_ALWAYS(a_queue_bound, clk, rst, count <= QueueCntW'(QueueDepth),
                 "result queue overflow")
  `ASSERT_NEXT(a_eop_restart, clk, rst, take && last,
               phase == PH_FIXED && byte_position == '0 && count != '0,
               "parser not restarted after last byte")
  `ASSERT_ALWAYS(a_pos_bound, clk, rst, byte_position <= MaxPos, "byte position past limit")
  `ASSERT_IMPLIES(a_fixed_pos, clk, rst, phase == PH_FIXED, byte_position < PosW'(12),
                  "fixed header phase past byte 11")
  `ASSERT_IMPLIES(a_csrc_left, clk, rst, phase == PH_CSRC, sources_left != 4'd0,
                  "csrc phase with no sources left")

endmodule

`default_nettype wire
